// ----- hdl/gaussian_upscale_2x_core_defines.svh -----
// Assertion macros for the 2x Gaussian upscaler core.
`ifndef GAUSSIAN_UPSCALE_2X_CORE_DEFINES_SVH
`define GAUSSIAN_UPSCALE_2X_CORE_DEFINES_SVH
`ifndef SYNTH
// Same-cycle implication, checked on aclk outside reset.
`define GU2X_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication, checked on aclk outside reset.
`define GU2X_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define GU2X_ASSERT_SAME(label, ante, cons)
`define GU2X_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ----- hdl/gu2x_pkg.sv -----
// Constants and register map of the 2x Gaussian upscaler.
package gu2x_pkg;
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);

    localparam logic [2:0] REG_IMAGE_WIDTH   = 3'd0;
    localparam logic [2:0] REG_IMAGE_HEIGHT  = 3'd1;
    localparam logic [2:0] REG_CHANNEL_COUNT = 3'd2;
    localparam logic [2:0] REG_WEIGHT_NEAR   = 3'd3;
    localparam logic [2:0] REG_WEIGHT_MID    = 3'd4;
    localparam logic [2:0] REG_WEIGHT_FAR    = 3'd5;

    localparam logic [10:0] RST_IMAGE_WIDTH   = 11'd1024;
    localparam logic [12:0] RST_IMAGE_HEIGHT  = 13'd1024;
    localparam logic [2:0]  RST_CHANNEL_COUNT = 3'd3;
    localparam logic [8:0]  RST_WEIGHT_NEAR   = 9'd129;
    localparam logic [8:0]  RST_WEIGHT_MID    = 9'd87;
    localparam logic [8:0]  RST_WEIGHT_FAR    = 9'd40;

    typedef logic [29:0] acc_t;
endpackage

// ----- hdl/gaussian_upscale_2x_core.sv -----
// 2x Gaussian upscaler: one input pixel in, up to sixteen filtered output pixels out.
// Input pixels arrive in raster order; each one closes the 3x3 neighborhoods of up to
// four 2x2 output blocks, which are then emitted one output word at a time. The two
// previous input rows live in one 1024 x 64-bit synchronous RAM (both rows of a column
// in one word), read and written back once per input pixel. Each output pixel is
// computed by four channel MAC lanes stepping over the nine window taps in turn, then a
// drain step and a load into the output word; candidate blocks are scanned one by one.
// An input pixel usually yields four outputs, and the next pixel is taken only once
// the current one has been fully emitted.
`include "gaussian_upscale_2x_core_defines.svh"
module gaussian_upscale_2x_core (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input pixels
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_in_ch0,
    input  logic [7:0]  s_in_ch1,
    input  logic [7:0]  s_in_ch2,
    input  logic [7:0]  s_in_ch3,
    // output pixels
    output logic        m_valid,
    input  logic        m_ready,
    output logic [10:0] m_out_x,
    output logic [12:0] m_out_y,
    output logic [7:0]  m_out_ch0,
    output logic [7:0]  m_out_ch1,
    output logic [7:0]  m_out_ch2,
    output logic [7:0]  m_out_ch3,
    output logic        m_last_of_run
);
    localparam int CW = gu2x_pkg::COL_W;
    localparam int RW = gu2x_pkg::ROW_W;

    typedef enum logic [2:0] {
        ST_IDLE, ST_READ, ST_UPD, ST_BLK, ST_MAC, ST_DRAIN, ST_OUT
    } state_t;

    state_t state_reg;

    // configuration registers
    logic [10:0] width_reg;
    logic [12:0] height_reg;
    logic [2:0]  chans_reg;
    logic [8:0]  w_near_reg, w_mid_reg, w_far_reg;

    // position and current pixel
    logic [CW-1:0] col_reg;
    logic [RW-1:0] row_reg;
    logic [CW-1:0] x_reg;
    logic [RW-1:0] y_reg;
    logic          last_c_reg, last_r_reg;
    logic [31:0]   pix_reg;

    // row store
    logic [63:0] mem [gu2x_pkg::MAX_WIDTH];
    logic [63:0] mem_rdata_reg;

    // window and emit control
    logic [31:0] win_reg [9];
    logic [3:0]  flags_reg;
    logic [1:0]  blk_reg, sub_reg, tap_r_reg, tap_c_reg;
    logic        acc_en_reg, first_reg;
    logic [17:0] wprod_reg;
    logic [31:0] psel_reg;
    gu2x_pkg::acc_t acc_reg [4];

    // output word
    logic        m_valid_reg, m_last_reg;
    logic [10:0] m_x_reg;
    logic [12:0] m_y_reg;
    logic [7:0]  m_ch_reg [4];

    // effective sizes
    logic [10:0] w_eff;
    logic [12:0] h_eff;
    logic [2:0]  ch_eff;
    logic        wrap;
    logic [CW-1:0] x_in;
    logic [RW-1:0] y_in;
    logic        last_c_in, last_r_in;
    logic        accept, out_free;

    always_comb begin
        w_eff = width_reg;
        if (width_reg == 11'd0) w_eff = 11'd1;
        else if (width_reg > 11'(gu2x_pkg::MAX_WIDTH)) w_eff = 11'(gu2x_pkg::MAX_WIDTH);
        h_eff = height_reg;
        if (height_reg == 13'd0) h_eff = 13'd1;
        else if (height_reg > 13'(gu2x_pkg::MAX_HEIGHT)) h_eff = 13'(gu2x_pkg::MAX_HEIGHT);
        ch_eff = chans_reg;
        if (chans_reg == 3'd0) ch_eff = 3'd1;
        else if (chans_reg > 3'd4) ch_eff = 3'd4;
        wrap = ({1'b0, col_reg} >= w_eff) || ({1'b0, row_reg} >= h_eff);
        x_in = wrap ? '0 : col_reg;
        y_in = wrap ? '0 : row_reg;
        last_c_in = ({1'b0, x_in} == (w_eff - 11'd1));
        last_r_in = ({1'b0, y_in} == (h_eff - 13'd1));
    end

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign pready   = 1'b1;

    // register file reads
    always_comb begin
        unique case (paddr[4:2])
            gu2x_pkg::REG_IMAGE_WIDTH:   prdata = {21'd0, width_reg};
            gu2x_pkg::REG_IMAGE_HEIGHT:  prdata = {19'd0, height_reg};
            gu2x_pkg::REG_CHANNEL_COUNT: prdata = {29'd0, chans_reg};
            gu2x_pkg::REG_WEIGHT_NEAR:   prdata = {23'd0, w_near_reg};
            gu2x_pkg::REG_WEIGHT_MID:    prdata = {23'd0, w_mid_reg};
            gu2x_pkg::REG_WEIGHT_FAR:    prdata = {23'd0, w_far_reg};
            default:                     prdata = 32'd0;
        endcase
    end

    // register file writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= gu2x_pkg::RST_IMAGE_WIDTH;
            height_reg <= gu2x_pkg::RST_IMAGE_HEIGHT;
            chans_reg  <= gu2x_pkg::RST_CHANNEL_COUNT;
            w_near_reg <= gu2x_pkg::RST_WEIGHT_NEAR;
            w_mid_reg  <= gu2x_pkg::RST_WEIGHT_MID;
            w_far_reg  <= gu2x_pkg::RST_WEIGHT_FAR;
        end else if (psel && penable && pwrite && pready) begin
            unique case (paddr[4:2])
                gu2x_pkg::REG_IMAGE_WIDTH:   width_reg  <= pwdata[10:0];
                gu2x_pkg::REG_IMAGE_HEIGHT:  height_reg <= pwdata[12:0];
                gu2x_pkg::REG_CHANNEL_COUNT: chans_reg  <= pwdata[2:0];
                gu2x_pkg::REG_WEIGHT_NEAR:   w_near_reg <= pwdata[8:0];
                gu2x_pkg::REG_WEIGHT_MID:    w_mid_reg  <= pwdata[8:0];
                gu2x_pkg::REG_WEIGHT_FAR:    w_far_reg  <= pwdata[8:0];
                default: ;
            endcase
        end
    end

    // row store update values
    logic [31:0] old1, old2, mid_px, top_px;
    always_comb begin
        old2   = y_reg[0] ? mem_rdata_reg[63:32] : mem_rdata_reg[31:0];
        old1   = y_reg[0] ? mem_rdata_reg[31:0]  : mem_rdata_reg[63:32];
        mid_px = (y_reg >= RW'(1)) ? old1 : pix_reg;
        top_px = (y_reg >= RW'(2)) ? old2 : mid_px;
    end

    // row store: read at the column, write back with the new pixel in its row half
    always_ff @(posedge aclk) begin
        mem_rdata_reg <= mem[x_reg];
        if (state_reg == ST_UPD) begin
            mem[x_reg] <= y_reg[0] ? {pix_reg, old1} : {old1, pix_reg};
        end
    end

    // tap weights and window index for the issued tap
    logic [8:0] wx, wy;
    logic [1:0] ci, ri;
    logic [3:0] win_idx;
    always_comb begin
        case (tap_c_reg)
            2'd0:    wx = sub_reg[0] ? w_far_reg : w_mid_reg;
            2'd1:    wx = w_near_reg;
            default: wx = sub_reg[0] ? w_mid_reg : w_far_reg;
        endcase
        case (tap_r_reg)
            2'd0:    wy = sub_reg[1] ? w_far_reg : w_mid_reg;
            2'd1:    wy = w_near_reg;
            default: wy = sub_reg[1] ? w_mid_reg : w_far_reg;
        endcase
        ci = (blk_reg[0] && tap_c_reg != 2'd2) ? tap_c_reg + 2'd1 : tap_c_reg;
        ri = (blk_reg[1] && tap_r_reg != 2'd2) ? tap_r_reg + 2'd1 : tap_r_reg;
        win_idx = 4'({2'b00, ri} * 4'd3 + {2'b00, ci});
    end

    // remaining blocks after the current one
    logic more_blk;
    always_comb begin
        more_blk = 1'b0;
        for (int i = 0; i < 4; i++) begin
            if (2'(i) > blk_reg && flags_reg[i]) more_blk = 1'b1;
        end
    end

    // output coordinates and saturated channels
    logic [10:0] cx;
    logic [12:0] cy;
    logic [7:0]  sat_ch [4];
    always_comb begin
        cx = {1'b0, x_reg} + {10'd0, blk_reg[0]} - 11'd1;
        cy = {1'b0, y_reg} + {12'd0, blk_reg[1]} - 13'd1;
        for (int i = 0; i < 4; i++) begin
            if (3'(i) >= ch_eff) sat_ch[i] = 8'd0;
            else if (acc_reg[i][29:16] > 14'd255) sat_ch[i] = 8'd255;
            else sat_ch[i] = acc_reg[i][23:16];
        end
    end

    // channel MAC lanes
    always_ff @(posedge aclk) begin
        wprod_reg <= 18'(wy * wx);
        psel_reg  <= win_reg[win_idx];
        for (int i = 0; i < 4; i++) begin
            if (acc_en_reg) begin
                if (first_reg) acc_reg[i] <= 30'(wprod_reg * psel_reg[8*i +: 8]);
                else acc_reg[i] <= acc_reg[i] + 30'(wprod_reg * psel_reg[8*i +: 8]);
            end
        end
    end

    // sequencer, window and output word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            col_reg     <= '0;
            row_reg     <= '0;
            acc_en_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            // lanes take the tap issued in the previous cycle
            acc_en_reg <= (state_reg == ST_MAC);
            // load a new word, or drop the one taken by the receiver
            if ((state_reg == ST_OUT) && out_free) m_valid_reg <= 1'b1;
            else if (m_ready) m_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        pix_reg    <= {s_in_ch3, s_in_ch2, s_in_ch1, s_in_ch0};
                        x_reg      <= x_in;
                        y_reg      <= y_in;
                        last_c_reg <= last_c_in;
                        last_r_reg <= last_r_in;
                        if (last_c_in) begin
                            col_reg <= '0;
                            row_reg <= last_r_in ? '0 : y_in + RW'(1);
                        end else begin
                            col_reg <= x_in + CW'(1);
                        end
                        state_reg <= ST_READ;
                    end
                end
                ST_READ: state_reg <= ST_UPD;
                ST_UPD: begin
                    for (int i = 0; i < 3; i++) begin
                        if (x_reg == '0) begin
                            win_reg[i*3]   <= (i == 0) ? top_px : (i == 1) ? mid_px : pix_reg;
                            win_reg[i*3+1] <= (i == 0) ? top_px : (i == 1) ? mid_px : pix_reg;
                        end else begin
                            win_reg[i*3]   <= win_reg[i*3+1];
                            win_reg[i*3+1] <= win_reg[i*3+2];
                        end
                        win_reg[i*3+2] <= (i == 0) ? top_px : (i == 1) ? mid_px : pix_reg;
                    end
                    flags_reg[0] <= (x_reg != '0) && (y_reg != '0);
                    flags_reg[1] <= last_c_reg && (y_reg != '0);
                    flags_reg[2] <= last_r_reg && (x_reg != '0);
                    flags_reg[3] <= last_c_reg && last_r_reg;
                    blk_reg   <= 2'd0;
                    state_reg <= ST_BLK;
                end
                ST_BLK: begin
                    if (flags_reg[blk_reg]) begin
                        sub_reg   <= 2'd0;
                        tap_r_reg <= 2'd0;
                        tap_c_reg <= 2'd0;
                        state_reg <= ST_MAC;
                    end else if (blk_reg == 2'd3) begin
                        state_reg <= ST_IDLE;
                    end else begin
                        blk_reg <= blk_reg + 2'd1;
                    end
                end
                ST_MAC: begin
                    // issue one tap to the lanes
                    first_reg  <= (tap_r_reg == 2'd0) && (tap_c_reg == 2'd0);
                    if (tap_c_reg == 2'd2) begin
                        tap_c_reg <= 2'd0;
                        tap_r_reg <= tap_r_reg + 2'd1;
                        if (tap_r_reg == 2'd2) state_reg <= ST_DRAIN;
                    end else begin
                        tap_c_reg <= tap_c_reg + 2'd1;
                    end
                end
                ST_DRAIN: state_reg <= ST_OUT;
                ST_OUT: begin
                    if (out_free) begin
                        m_x_reg     <= {cx[9:0], sub_reg[0]};
                        m_y_reg     <= {cy[11:0], sub_reg[1]};
                        for (int i = 0; i < 4; i++) m_ch_reg[i] <= sat_ch[i];
                        m_last_reg  <= (sub_reg == 2'd3) && !more_blk;
                        tap_r_reg   <= 2'd0;
                        tap_c_reg   <= 2'd0;
                        if (sub_reg == 2'd3) begin
                            if (blk_reg == 2'd3) begin
                                state_reg <= ST_IDLE;
                            end else begin
                                blk_reg   <= blk_reg + 2'd1;
                                state_reg <= ST_BLK;
                            end
                        end else begin
                            sub_reg   <= sub_reg + 2'd1;
                            state_reg <= ST_MAC;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_out_x       = m_x_reg;
    assign m_out_y       = m_y_reg;
    assign m_out_ch0     = m_ch_reg[0];
    assign m_out_ch1     = m_ch_reg[1];
    assign m_out_ch2     = m_ch_reg[2];
    assign m_out_ch3     = m_ch_reg[3];
    assign m_last_of_run = m_last_reg;

    `GU2X_ASSERT_NEXT(a_one_pixel_at_a_time, accept, !s_ready)
    `GU2X_ASSERT_SAME(a_lanes_only_in_mac, acc_en_reg, (state_reg == ST_MAC) || (state_reg == ST_DRAIN))
    `GU2X_ASSERT_NEXT(a_out_waits_on_stall, (state_reg == ST_OUT) && m_valid_reg && !m_ready, state_reg == ST_OUT)
endmodule
